>>> rtl/wsd_pkg.sv
// ============================================================================
// wsd_pkg: shared types and constants for the WebSocket frame deframer
// Parse phases, result kinds, length codes and the command word passed
// from the header parser to the unmask/output stage.
// ============================================================================
package wsd_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Second-byte length codes that extend the length field
    localparam logic [6:0] LEN_CODE16 = 7'd126;
    localparam logic [6:0] LEN_CODE64 = 7'd127;

    // Header byte counts for the extended length and masking key
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // Default depth of the command queue
    localparam int QUEUE_DEPTH = 2;

    // Command word: one result, byte still masked
    typedef struct packed {
        logic [1:0]  kind;
        logic        fin;
        logic [3:0]  opcode;
        logic [62:0] length;
        logic [7:0]  raw_byte;
        logic [7:0]  key_byte;
        logic        frame_end;
    } cmd_t;

endpackage

>>> rtl/websocket_frame_deframer.sv
// ============================================================================
// websocket_frame_deframer: WebSocket receive-side frame parser
// Top level: header parser, command queue and unmask/output stage.
// ============================================================================
// Accepts one stream byte per cycle whenever full is low and delivers at most
// one result word per byte: a header word when the header completes (marked
// frame_end for a zero-length frame), one unmasked payload word per payload
// byte, or a length-error word when a 64-bit length has its top bit set. Each
// command enters the queue when its byte is accepted and moves into the output
// register once that register is free or being popped. Sustained rate is one
// byte per cycle while full is low; the parser updates its state once per
// byte, and the command queue (QUEUE_DEPTH words) plus the output register let
// input and output stall independently. full rises once the queue holds
// QUEUE_DEPTH words, which stalls every input byte, header bytes included,
// until the output is popped.
module websocket_frame_deframer #(
    parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  stream_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic        final_fragment,
    output logic [3:0]  frame_opcode,
    output logic [62:0] payload_length,
    output logic [7:0]  payload_byte,
    output logic        frame_end
);
    import wsd_pkg::*;

    logic accept;
    logic cmd_push;
    cmd_t cmd_in;
    logic q_valid;
    logic q_pop;
    cmd_t cmd_out;

    assign accept = push && !full;

    // Header parser
    wsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .stream_byte(stream_byte),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    // Command queue
    wsd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_valid(q_valid),
        .rd_en   (q_pop),
        .rd_data (cmd_out)
    );

    // Unmask and output
    wsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (q_valid),
        .cmd           (cmd_out),
        .cmd_pop       (q_pop),
        .pop           (pop),
        .empty         (empty),
        .kind          (kind),
        .final_fragment(final_fragment),
        .frame_opcode  (frame_opcode),
        .payload_length(payload_length),
        .payload_byte  (payload_byte),
        .frame_end     (frame_end)
    );

endmodule

>>> rtl/wsd_front.sv
// ============================================================================
// wsd_front: frame header parser
// Takes one stream byte per accepted word, walks the header, collects the
// length and masking key, and issues one command per result.
// ============================================================================
module wsd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    stream_byte,
    output logic          cmd_push,
    output wsd_pkg::cmd_t cmd
);
    import wsd_pkg::*;

    phase_t      parse_phase_reg, parse_phase_next;
    logic [3:0]  header_byte_count_reg, header_byte_count_next;
    logic [63:0] length_accumulator_reg, length_accumulator_next;
    logic        mask_present_reg, mask_present_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [63:0] payload_remaining_reg, payload_remaining_next;
    logic [1:0]  payload_index_low_reg, payload_index_low_next;
    logic        held_fin_reg, held_fin_next;
    logic [3:0]  held_opcode_reg, held_opcode_next;

    logic        length_ready;
    logic        header_done;
    logic [63:0] shifted_length;
    logic [3:0]  count_inc;
    logic [63:0] remaining_dec;
    logic [62:0] header_length;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase_reg        <= PH_FIRST;
            header_byte_count_reg  <= '0;
            length_accumulator_reg <= '0;
            mask_present_reg       <= 1'b0;
            mask_key_reg           <= '0;
            payload_remaining_reg  <= '0;
            payload_index_low_reg  <= '0;
            held_fin_reg           <= 1'b0;
            held_opcode_reg        <= '0;
        end
        else
        begin
            parse_phase_reg        <= parse_phase_next;
            header_byte_count_reg  <= header_byte_count_next;
            length_accumulator_reg <= length_accumulator_next;
            mask_present_reg       <= mask_present_next;
            mask_key_reg           <= mask_key_next;
            payload_remaining_reg  <= payload_remaining_next;
            payload_index_low_reg  <= payload_index_low_next;
            held_fin_reg           <= held_fin_next;
            held_opcode_reg        <= held_opcode_next;
        end
    end

    assign shifted_length = {length_accumulator_reg[55:0], stream_byte};
    assign count_inc      = header_byte_count_reg + 4'd1;
    assign remaining_dec  = payload_remaining_reg - 64'd1;

    // Next state and command
    always_comb
    begin
        parse_phase_next        = parse_phase_reg;
        header_byte_count_next  = header_byte_count_reg;
        length_accumulator_next = length_accumulator_reg;
        mask_present_next       = mask_present_reg;
        mask_key_next           = mask_key_reg;
        payload_remaining_next  = payload_remaining_reg;
        payload_index_low_next  = payload_index_low_reg;
        held_fin_next           = held_fin_reg;
        held_opcode_next        = held_opcode_reg;
        length_ready            = 1'b0;
        header_done             = 1'b0;
        header_length           = '0;
        cmd_push                = 1'b0;
        cmd.kind                = KIND_HEADER;
        cmd.fin                 = held_fin_reg;
        cmd.opcode              = held_opcode_reg;
        cmd.length              = '0;
        cmd.raw_byte            = '0;
        cmd.key_byte            = '0;
        cmd.frame_end           = 1'b0;

        if (accept)
        begin
            unique case (parse_phase_reg)
                PH_SECOND:
                begin
                    mask_present_next       = stream_byte[7];
                    length_accumulator_next = '0;
                    header_byte_count_next  = '0;
                    if (stream_byte[6:0] == LEN_CODE16)
                        parse_phase_next = PH_EXT16;
                    else if (stream_byte[6:0] == LEN_CODE64)
                        parse_phase_next = PH_EXT64;
                    else
                    begin
                        length_accumulator_next = {57'd0, stream_byte[6:0]};
                        length_ready            = 1'b1;
                    end
                end
                PH_EXT16:
                begin
                    length_accumulator_next = {48'd0, shifted_length[15:0]};
                    header_byte_count_next  = count_inc;
                    if (count_inc >= EXT16_BYTES)
                        length_ready = 1'b1;
                end
                PH_EXT64:
                begin
                    length_accumulator_next = shifted_length;
                    header_byte_count_next  = count_inc;
                    if (count_inc >= EXT64_BYTES)
                    begin
                        if (shifted_length[63])
                        begin
                            // Length out of range: report and resync on next header
                            header_byte_count_next  = '0;
                            length_accumulator_next = '0;
                            mask_present_next       = 1'b0;
                            parse_phase_next        = PH_FIRST;
                            cmd_push                = 1'b1;
                            cmd.kind                = KIND_ERROR;
                            cmd.frame_end           = 1'b1;
                        end
                        else
                            length_ready = 1'b1;
                    end
                end
                PH_MASK:
                begin
                    mask_key_next          = {mask_key_reg[23:0], stream_byte};
                    header_byte_count_next = count_inc;
                    if (count_inc >= KEY_BYTES)
                        header_done = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    payload_index_low_next = payload_index_low_reg + 2'd1;
                    if (payload_remaining_reg != '0)
                        payload_remaining_next = remaining_dec;
                    cmd_push     = 1'b1;
                    cmd.kind     = KIND_PAYLOAD;
                    cmd.raw_byte = stream_byte;
                    if (mask_present_reg)
                        cmd.key_byte = mask_key_reg[{~payload_index_low_reg, 3'b000} +: 8];
                    if (payload_remaining_next == '0)
                    begin
                        parse_phase_next = PH_FIRST;
                        cmd.frame_end    = 1'b1;
                    end
                end
                default:
                begin
                    // First header byte (also recovers from unused phase codes)
                    held_fin_next          = stream_byte[7];
                    held_opcode_next       = stream_byte[3:0];
                    header_byte_count_next = '0;
                    parse_phase_next       = PH_SECOND;
                end
            endcase

            // Length known: collect key or finish header
            if (length_ready)
            begin
                header_byte_count_next = '0;
                mask_key_next          = '0;
                if (mask_present_next)
                    parse_phase_next = PH_MASK;
                else
                    header_done = 1'b1;
            end

            // Header complete: issue header result
            if (header_done)
            begin
                header_length          = length_accumulator_next[62:0];
                header_byte_count_next = '0;
                payload_index_low_next = '0;
                cmd_push               = 1'b1;
                cmd.kind               = KIND_HEADER;
                cmd.length             = header_length;
                if (header_length == '0)
                begin
                    payload_remaining_next = '0;
                    parse_phase_next       = PH_FIRST;
                    cmd.frame_end          = 1'b1;
                end
                else
                begin
                    payload_remaining_next = {1'b0, header_length};
                    parse_phase_next       = PH_PAYLOAD;
                end
            end
        end
    end

    // Payload phase always has bytes left
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        parse_phase_reg == PH_PAYLOAD |-> payload_remaining_reg != '0)
        else $error("payload phase with zero bytes remaining");

    // Error result resyncs to the first header byte
    a_error_resync: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push && cmd.kind == KIND_ERROR |=> parse_phase_reg == PH_FIRST && !mask_present_reg)
        else $error("length error did not return to header parsing");

    // Header byte count never exceeds the longest extended field
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_byte_count_reg <= EXT64_BYTES)
        else $error("header byte count out of range");

endmodule

>>> rtl/wsd_queue.sv
// ============================================================================
// wsd_queue: command queue between parser and output stage
// Small register queue so the parser and output stage stall independently.
// ============================================================================
module wsd_queue #(
    parameter int DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  wsd_pkg::cmd_t wr_data,
    output logic          full,
    output logic          rd_valid,
    input  logic          rd_en,
    output wsd_pkg::cmd_t rd_data
);
    import wsd_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    cmd_t            mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_wr;
    logic            do_rd;

    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign full     = (count_reg == FullCnt);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CntW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Occupancy stays within depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCnt)
        else $error("queue count above depth");

    // Count tracks a lone write
    a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
        do_wr && !do_rd |=> count_reg == $past(count_reg) + CntW'(1))
        else $error("queue count missed a write");

    // Pointers agree when the queue is empty
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue empty with mismatched pointers");

endmodule

>>> rtl/wsd_back.sv
// ============================================================================
// wsd_back: unmask and output stage
// Pulls commands from the queue, applies the mask byte and holds the
// oldest result on the output word until it is popped.
// ============================================================================
module wsd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  wsd_pkg::cmd_t cmd,
    output logic          cmd_pop,
    input  logic          pop,
    output logic          empty,
    output logic [1:0]    kind,
    output logic          final_fragment,
    output logic [3:0]    frame_opcode,
    output logic [62:0]   payload_length,
    output logic [7:0]    payload_byte,
    output logic          frame_end
);
    import wsd_pkg::*;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic        fin_reg;
    logic [3:0]  opcode_reg;
    logic [62:0] length_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;

    // Load when the output word is free or leaving this cycle
    assign cmd_pop = cmd_valid && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd_pop)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    // Output word, byte unmasked on load
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            kind_reg   <= cmd.kind;
            fin_reg    <= cmd.fin;
            opcode_reg <= cmd.opcode;
            length_reg <= cmd.length;
            byte_reg   <= cmd.raw_byte ^ cmd.key_byte;
            end_reg    <= cmd.frame_end;
        end
    end

    assign empty          = !out_valid_reg;
    assign kind           = kind_reg;
    assign final_fragment = fin_reg;
    assign frame_opcode   = opcode_reg;
    assign payload_length = length_reg;
    assign payload_byte   = byte_reg;
    assign frame_end      = end_reg;

endmodule
